### hw/rtl/lprd_pkg.sv
// ----------------------------------------------------------------------------
// lprd_pkg : LAS point record decoder package
// Field tags, register indexes, record layout lookup and flag byte splitting.
// ----------------------------------------------------------------------------
package lprd_pkg;

  // register indexes on the config port
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_FORMAT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_BYTES  = CFG_IDX_W'(1);

  // field tags
  localparam logic [4:0] TAG_X          = 5'd0;
  localparam logic [4:0] TAG_Y          = 5'd1;
  localparam logic [4:0] TAG_Z          = 5'd2;
  localparam logic [4:0] TAG_INTENSITY  = 5'd3;
  localparam logic [4:0] TAG_RETURN_NUM = 5'd4;
  localparam logic [4:0] TAG_NUM_RET    = 5'd5;
  localparam logic [4:0] TAG_SCAN_DIR   = 5'd6;
  localparam logic [4:0] TAG_EDGE       = 5'd7;
  localparam logic [4:0] TAG_CLASS      = 5'd8;
  localparam logic [4:0] TAG_SYNTHETIC  = 5'd9;
  localparam logic [4:0] TAG_KEY_POINT  = 5'd10;
  localparam logic [4:0] TAG_WITHHELD   = 5'd11;
  localparam logic [4:0] TAG_OVERLAP    = 5'd12;
  localparam logic [4:0] TAG_CHANNEL    = 5'd13;
  localparam logic [4:0] TAG_SCAN_ANGLE = 5'd14;
  localparam logic [4:0] TAG_USER       = 5'd15;
  localparam logic [4:0] TAG_SOURCE_ID  = 5'd16;
  localparam logic [4:0] TAG_GPS_TIME   = 5'd17;
  localparam logic [4:0] TAG_RED        = 5'd18;
  localparam logic [4:0] TAG_NIR        = 5'd21;
  localparam logic [4:0] TAG_WAVE_DESC  = 5'd22;
  localparam logic [4:0] TAG_WAVE_OFS   = 5'd23;
  localparam logic [4:0] TAG_WAVE_SIZE  = 5'd24;
  localparam logic [4:0] TAG_EXTRA      = 5'd29;

  // record layout sizes
  localparam logic [4:0] LEGACY_CORE_SIZE = 5'd20;
  localparam logic [4:0] EXT_CORE_SIZE    = 5'd22;  // extended core without GPS time
  localparam logic [6:0] GPS_SIZE         = 7'd8;
  localparam logic [6:0] RGB_SIZE         = 7'd6;
  localparam logic [6:0] NIR_SIZE         = 7'd2;
  localparam logic [6:0] WAVE_SIZE        = 7'd29;
  localparam logic [3:0] LAST_LEGACY_FMT  = 4'd5;

  // flag masks
  localparam logic [7:0] LEG_RET_MASK   = 8'b00000111;
  localparam logic [7:0] LEG_NRET_MASK  = 8'b00111000;
  localparam logic [7:0] LEG_CLASS_MASK = 8'b00011111;
  localparam logic [7:0] EXT_RET_MASK   = 8'b00001111;
  localparam logic [7:0] EXT_NRET_MASK  = 8'b11110000;
  localparam logic [7:0] EXT_CHAN_MASK  = 8'b00110000;

  // what a finished field expands into
  typedef enum logic [2:0] {
    RUN_FIELD = 3'd0,
    RUN_LEG_A = 3'd1,
    RUN_LEG_B = 3'd2,
    RUN_EXT_A = 3'd3,
    RUN_EXT_B = 3'd4
  } run_kind_t;

  typedef struct packed {
    logic       in_std;     // position lies in the standard part
    run_kind_t  kind;
    logic [4:0] tag;
    logic       last;       // byte closes its field
    logic [6:0] std_size;
  } lookup_t;

  typedef struct packed {
    logic [4:0] tag;
    logic [7:0] value;
  } flag_out_t;

  function automatic lookup_t layout_lookup(input logic [3:0] fmt, input logic [8:0] pos);
    logic       legacy;
    logic       gps;
    logic       rgb;
    logic       nir;
    logic       wav;
    logic       found;
    logic [4:0] core;
    logic [4:0] p;
    logic [8:0] o;
    logic [8:0] w;
    lookup_t    r;
    legacy = (fmt <= LAST_LEGACY_FMT);
    gps = (fmt == 4'd1) || (fmt == 4'd3) || (fmt >= 4'd6);
    rgb = (fmt == 4'd2) || (fmt == 4'd3) || (fmt == 4'd5) || (fmt == 4'd7) ||
          (fmt == 4'd8) || (fmt == 4'd10);
    nir = (fmt == 4'd8) || (fmt == 4'd10);
    wav = (fmt == 4'd4) || (fmt == 4'd5) || (fmt == 4'd9) || (fmt == 4'd10);
    core = legacy ? LEGACY_CORE_SIZE : EXT_CORE_SIZE;
    r.std_size = {2'b00, core} + (gps ? GPS_SIZE : 7'd0) + (rgb ? RGB_SIZE : 7'd0) +
                 (nir ? NIR_SIZE : 7'd0) + (wav ? WAVE_SIZE : 7'd0);
    r.in_std = (pos < {2'b00, r.std_size});
    r.kind = RUN_FIELD;
    r.tag = TAG_X;
    r.last = 1'b0;
    found = 1'b0;
    p = pos[4:0];
    o = pos - {4'd0, core};
    w = o - 9'd9;
    if (pos < {4'd0, core}) begin
      if (p < 5'd4) begin
        r.tag = TAG_X; r.last = (p == 5'd3);
      end else if (p < 5'd8) begin
        r.tag = TAG_Y; r.last = (p == 5'd7);
      end else if (p < 5'd12) begin
        r.tag = TAG_Z; r.last = (p == 5'd11);
      end else if (p < 5'd14) begin
        r.tag = TAG_INTENSITY; r.last = (p == 5'd13);
      end else if (p == 5'd14) begin
        r.kind = legacy ? RUN_LEG_A : RUN_EXT_A; r.last = 1'b1;
      end else if (p == 5'd15) begin
        r.kind = legacy ? RUN_LEG_B : RUN_EXT_B; r.last = 1'b1;
      end else if (p == 5'd16) begin
        r.tag = legacy ? TAG_SCAN_ANGLE : TAG_CLASS; r.last = 1'b1;
      end else if (p == 5'd17) begin
        r.tag = TAG_USER; r.last = 1'b1;
      end else if (legacy) begin
        r.tag = TAG_SOURCE_ID; r.last = (p == 5'd19);
      end else if (p < 5'd20) begin
        r.tag = TAG_SCAN_ANGLE; r.last = (p == 5'd19);
      end else begin
        r.tag = TAG_SOURCE_ID; r.last = (p == 5'd21);
      end
    end else begin
      // walk the optional blocks in order, each one rebasing the offset
      if (gps) begin
        if (o < 9'd8) begin
          r.tag = TAG_GPS_TIME; r.last = (o == 9'd7); found = 1'b1;
        end else begin
          o = o - 9'd8;
        end
      end
      if (rgb && !found) begin
        if (o < 9'd6) begin
          r.tag = TAG_RED + {3'b000, o[2:1]}; r.last = o[0]; found = 1'b1;
        end else begin
          o = o - 9'd6;
        end
      end
      if (nir && !found) begin
        if (o < 9'd2) begin
          r.tag = TAG_NIR; r.last = o[0]; found = 1'b1;
        end else begin
          o = o - 9'd2;
        end
      end
      w = o - 9'd9;
      if (wav && !found) begin
        if (o == 9'd0) begin
          r.tag = TAG_WAVE_DESC; r.last = 1'b1;
        end else if (o < 9'd9) begin
          r.tag = TAG_WAVE_OFS; r.last = (o == 9'd8);
        end else begin
          r.tag = TAG_WAVE_SIZE + {2'b00, w[4:2]}; r.last = (w[1:0] == 2'd3);
        end
      end
    end
    return r;
  endfunction

  // index of the final result of a run
  function automatic logic [2:0] run_last_idx(input run_kind_t kind);
    logic [2:0] n;
    case (kind)
      RUN_FIELD: n = 3'd0;
      RUN_LEG_A: n = 3'd3;
      RUN_LEG_B: n = 3'd3;
      RUN_EXT_A: n = 3'd1;
      RUN_EXT_B: n = 3'd6;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  // subfields of a packed flag byte, ascending bit order
  function automatic flag_out_t flag_result(input run_kind_t kind, input logic [2:0] idx,
                                            input logic [7:0] b);
    flag_out_t r;
    r.tag = TAG_X;
    r.value = 8'd0;
    case (kind)
      RUN_LEG_A: begin
        case (idx)
          3'd0: begin r.tag = TAG_RETURN_NUM; r.value = b & LEG_RET_MASK; end
          3'd1: begin r.tag = TAG_NUM_RET; r.value = (b & LEG_NRET_MASK) >> 3; end
          3'd2: begin r.tag = TAG_SCAN_DIR; r.value = {7'd0, b[6]}; end
          default: begin r.tag = TAG_EDGE; r.value = {7'd0, b[7]}; end
        endcase
      end
      RUN_LEG_B: begin
        case (idx)
          3'd0: begin r.tag = TAG_CLASS; r.value = b & LEG_CLASS_MASK; end
          3'd1: begin r.tag = TAG_SYNTHETIC; r.value = {7'd0, b[5]}; end
          3'd2: begin r.tag = TAG_KEY_POINT; r.value = {7'd0, b[6]}; end
          default: begin r.tag = TAG_WITHHELD; r.value = {7'd0, b[7]}; end
        endcase
      end
      RUN_EXT_A: begin
        case (idx)
          3'd0: begin r.tag = TAG_RETURN_NUM; r.value = b & EXT_RET_MASK; end
          default: begin r.tag = TAG_NUM_RET; r.value = (b & EXT_NRET_MASK) >> 4; end
        endcase
      end
      RUN_EXT_B: begin
        case (idx)
          3'd0: begin r.tag = TAG_SYNTHETIC; r.value = {7'd0, b[0]}; end
          3'd1: begin r.tag = TAG_KEY_POINT; r.value = {7'd0, b[1]}; end
          3'd2: begin r.tag = TAG_WITHHELD; r.value = {7'd0, b[2]}; end
          3'd3: begin r.tag = TAG_OVERLAP; r.value = {7'd0, b[3]}; end
          3'd4: begin r.tag = TAG_CHANNEL; r.value = (b & EXT_CHAN_MASK) >> 4; end
          3'd5: begin r.tag = TAG_SCAN_DIR; r.value = {7'd0, b[6]}; end
          default: begin r.tag = TAG_EDGE; r.value = {7'd0, b[7]}; end
        endcase
      end
      default: begin
        r.tag = TAG_X;
        r.value = 8'd0;
      end
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/lidar_point_record_decoder_unit.sv
// ----------------------------------------------------------------------------
// lidar_point_record_decoder_unit : LAS point record stream decoder
// Splits a byte stream of point records (formats 0 to 10) into tagged fields.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one stream byte per word (valid/ready). Records run back to back.
//   out_*  : one decoded field per word: tag, raw little-endian bits (zero
//            extended), last_of_run on the final word caused by a byte and
//            record_end on the word that closes a record.
//   cfg_*  : write-only registers, point format and extra byte count. A write
//            restarts the record parser at byte zero. Write only while idle.
// Latency: a byte that closes a field shows its first word the cycle after it
//   is taken. Bytes inside a multi-byte field give no word.
// Throughput: one word per cycle out of the run register while out_ready is
//   high. A byte makes as many words as its run holds: 1 for a plain field or
//   extra byte, 2 or 4 or 7 for the packed flag bytes. A new byte is taken in
//   the same cycle the last word of the previous run leaves, so plain fields
//   stream at one byte per cycle while out_ready stays high.
// Stall: when out_ready is low the run register holds and in_ready drops
//   until the final word of the run is taken.
// Reset: rst_n (sync, active low) selects format 0, no extra bytes, start of
//   record, empty output.
// ----------------------------------------------------------------------------
module lidar_point_record_decoder_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [4:0]                      out_field_tag,
  output logic [63:0]                     out_field_value,
  output logic                            out_last_of_run,
  output logic                            out_record_end,
  input  logic                            cfg_we,
  input  logic [lprd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_wdata
);
  import lprd_pkg::*;

  // config registers
  logic [3:0]  fmt_r;
  logic [7:0]  extra_r;

  // parser state
  logic [8:0]  pos_r, pos_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  // run register: one decoded byte waiting to be expanded into words
  logic        run_valid_r;
  run_kind_t   run_kind_r, run_kind_nxt;
  logic [4:0]  run_tag_r, run_tag_nxt;
  logic [63:0] run_val_r, run_val_nxt;
  logic        run_end_r, run_end_nxt;
  logic [2:0]  run_idx_r;

  lookup_t     lk;
  logic [63:0] acc_cur;
  logic [9:0]  total;
  logic [8:0]  pos_inc;
  logic        produce;
  logic        rec_done;
  logic        in_fire;
  logic        out_fire;
  logic        run_last;
  flag_out_t   flg;

  assign lk      = layout_lookup(fmt_r, pos_r);
  assign total   = {3'b000, lk.std_size} + {2'b00, extra_r};
  assign pos_inc = pos_r + 9'd1;
  assign rec_done = ({1'b0, pos_inc} >= total);

  // little-endian gather of the current byte into the field
  assign acc_cur = (cnt_r < 4'd8) ?
                   (acc_r | ({56'd0, in_data_byte} << {cnt_r[2:0], 3'b000})) : acc_r;

  assign run_last = (run_idx_r == run_last_idx(run_kind_r));
  assign out_fire = out_valid && out_ready;
  assign in_ready = !run_valid_r || (out_ready && run_last);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    produce      = 1'b0;
    run_kind_nxt = RUN_FIELD;
    run_tag_nxt  = TAG_EXTRA;
    run_val_nxt  = {56'd0, in_data_byte};
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    if (!lk.in_std) begin
      // trailing opaque byte, field state untouched
      produce = 1'b1;
    end else begin
      acc_nxt = acc_cur;
      cnt_nxt = cnt_r + 4'd1;
      if (lk.last) begin
        produce      = 1'b1;
        run_kind_nxt = lk.kind;
        run_tag_nxt  = lk.tag;
        run_val_nxt  = acc_cur;
        acc_nxt      = 64'd0;
        cnt_nxt      = 4'd0;
      end
    end
    run_end_nxt = rec_done;
    pos_nxt     = pos_inc;
    if (rec_done) begin
      pos_nxt = 9'd0;
      acc_nxt = 64'd0;
      cnt_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= 4'd0;
      extra_r <= 8'd0;
      pos_r   <= 9'd0;
      acc_r   <= 64'd0;
      cnt_r   <= 4'd0;
    end else if (cfg_we && (cfg_index == CFG_POINT_FORMAT)) begin
      fmt_r <= cfg_wdata[3:0];
      pos_r <= 9'd0;
      acc_r <= 64'd0;
      cnt_r <= 4'd0;
    end else if (cfg_we && (cfg_index == CFG_EXTRA_BYTES)) begin
      extra_r <= cfg_wdata;
      pos_r   <= 9'd0;
      acc_r   <= 64'd0;
      cnt_r   <= 4'd0;
    end else if (in_fire) begin
      pos_r <= pos_nxt;
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // run control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      run_idx_r   <= 3'd0;
    end else if (in_fire && produce) begin
      run_valid_r <= 1'b1;
      run_idx_r   <= 3'd0;
    end else if (out_fire && run_last) begin
      run_valid_r <= 1'b0;
      run_idx_r   <= 3'd0;
    end else if (out_fire) begin
      run_idx_r <= run_idx_r + 3'd1;
    end
  end

  // run payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire && produce) begin
      run_kind_r <= run_kind_nxt;
      run_tag_r  <= run_tag_nxt;
      run_val_r  <= run_val_nxt;
      run_end_r  <= run_end_nxt;
    end
  end

  assign flg = flag_result(run_kind_r, run_idx_r, run_val_r[7:0]);

  assign out_valid       = run_valid_r;
  assign out_field_tag   = (run_kind_r == RUN_FIELD) ? run_tag_r : flg.tag;
  assign out_field_value = (run_kind_r == RUN_FIELD) ? run_val_r : {56'd0, flg.value};
  assign out_last_of_run = run_last;
  assign out_record_end  = run_end_r && run_last;

  // ------------------------------------------------------------------ checks
  a_pos_in_record: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pos_r} < total)
    else $error("record position beyond record length");

  a_field_short: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < 4'd8)
    else $error("field gathered more than eight bytes");

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid_r |-> (run_idx_r <= run_last_idx(run_kind_r)))
    else $error("run index past end of run");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (run_valid_r && !out_ready) |=> (run_valid_r && $stable(run_idx_r)))
    else $error("run advanced while receiver stalled");

  a_no_take_midrun: assert property (@(posedge clk) disable iff (!rst_n)
    (run_valid_r && !run_last) |-> !in_ready)
    else $error("byte taken in the middle of a run");

endmodule

### test/tb_lidar_point_record_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_lidar_point_record_decoder_unit : point record decoder testbench
// Streams LAS point record bytes through the decoder under several register
// settings and idle patterns, and checks every decoded field word against a
// behavioral decoder kept in the bench.
// ----------------------------------------------------------------------------
module tb_lidar_point_record_decoder_unit;
  import lprd_pkg::*;

  // tags the package does not name
  localparam logic [4:0] TAG_GREEN    = 5'd19;
  localparam logic [4:0] TAG_BLUE     = 5'd20;
  localparam logic [4:0] TAG_WAVE_LOC = 5'd25;
  localparam logic [4:0] TAG_WAVE_XT  = 5'd26;
  localparam logic [4:0] TAG_WAVE_YT  = 5'd27;
  localparam logic [4:0] TAG_WAVE_ZT  = 5'd28;

  localparam int RUN_LIMIT    = 200000;  // cycles before the run is called hung
  localparam int DRAIN_CYCLES = 4;       // settle time after the last word
  localparam int HOLD_CYCLES  = 150;     // receiver hold-off in the pressure test
  localparam int PHASE_BYTES  = 25;      // rough stream length per random phase
  localparam int MAX_SEGS     = 32;

  typedef struct packed {
    logic [4:0]  tag;
    logic [63:0] value;
    logic        last;
    logic        rec_end;
  } field_word_t;

  // DUT ports
  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_data_byte = 8'd0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [4:0]           out_field_tag;
  logic [63:0]          out_field_value;
  logic                 out_last_of_run;
  logic                 out_record_end;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata = 8'd0;

  // decoder state mirrored in the bench
  logic [3:0]  fmt_reg;
  logic [7:0]  extra_reg;
  logic [8:0]  rec_pos;
  logic [63:0] field_acc;
  logic [3:0]  field_cnt;

  // record layout for the current format, one entry per field
  run_kind_t   seg_kind [MAX_SEGS];
  logic [4:0]  seg_tag  [MAX_SEGS];
  int          seg_size [MAX_SEGS];
  int          seg_count;
  int          std_bytes;

  field_word_t pending_fields[$];   // decoded words still to come out

  // traffic shaping
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_request  = 1'b0;
  int hold_left     = 0;

  // bookkeeping
  int          fail_count         = 0;
  int          bytes_sent         = 0;
  int          words_checked      = 0;
  int          records_closed     = 0;
  int          cycle_count        = 0;
  int          input_stall_cycles = 0;
  logic [15:0] formats_seen       = 16'h0001;

  lidar_point_record_decoder_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_field_tag   (out_field_tag),
    .out_field_value (out_field_value),
    .out_last_of_run (out_last_of_run),
    .out_record_end  (out_record_end),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioral decoder
  // --------------------------------------------------------------------------

  function automatic void add_seg(input run_kind_t k, input logic [4:0] t, input int sz);
    seg_kind[seg_count] = k;
    seg_tag[seg_count]  = t;
    seg_size[seg_count] = sz;
    seg_count++;
    std_bytes += sz;
  endfunction

  // Field list of a record. Formats 11..15 fall out as format 6 (GPS only).
  function automatic void load_layout();
    logic legacy;
    logic gps;
    logic rgb;
    logic nir;
    logic wav;
    legacy = (fmt_reg <= LAST_LEGACY_FMT);
    gps = (fmt_reg == 4'd1) || (fmt_reg == 4'd3) || (fmt_reg >= 4'd6);
    rgb = (fmt_reg == 4'd2) || (fmt_reg == 4'd3) || (fmt_reg == 4'd5) ||
          (fmt_reg == 4'd7) || (fmt_reg == 4'd8) || (fmt_reg == 4'd10);
    nir = (fmt_reg == 4'd8) || (fmt_reg == 4'd10);
    wav = (fmt_reg == 4'd4) || (fmt_reg == 4'd5) || (fmt_reg == 4'd9) ||
          (fmt_reg == 4'd10);
    seg_count = 0;
    std_bytes = 0;
    add_seg(RUN_FIELD, TAG_X, 4);
    add_seg(RUN_FIELD, TAG_Y, 4);
    add_seg(RUN_FIELD, TAG_Z, 4);
    add_seg(RUN_FIELD, TAG_INTENSITY, 2);
    if (legacy) begin
      add_seg(RUN_LEG_A, TAG_X, 1);
      add_seg(RUN_LEG_B, TAG_X, 1);
      add_seg(RUN_FIELD, TAG_SCAN_ANGLE, 1);
      add_seg(RUN_FIELD, TAG_USER, 1);
      add_seg(RUN_FIELD, TAG_SOURCE_ID, 2);
    end else begin
      add_seg(RUN_EXT_A, TAG_X, 1);
      add_seg(RUN_EXT_B, TAG_X, 1);
      add_seg(RUN_FIELD, TAG_CLASS, 1);
      add_seg(RUN_FIELD, TAG_USER, 1);
      add_seg(RUN_FIELD, TAG_SCAN_ANGLE, 2);
      add_seg(RUN_FIELD, TAG_SOURCE_ID, 2);
    end
    if (gps) add_seg(RUN_FIELD, TAG_GPS_TIME, 8);
    if (rgb) begin
      add_seg(RUN_FIELD, TAG_RED, 2);
      add_seg(RUN_FIELD, TAG_GREEN, 2);
      add_seg(RUN_FIELD, TAG_BLUE, 2);
    end
    if (nir) add_seg(RUN_FIELD, TAG_NIR, 2);
    if (wav) begin
      add_seg(RUN_FIELD, TAG_WAVE_DESC, 1);
      add_seg(RUN_FIELD, TAG_WAVE_OFS, 8);
      add_seg(RUN_FIELD, TAG_WAVE_SIZE, 4);
      add_seg(RUN_FIELD, TAG_WAVE_LOC, 4);
      add_seg(RUN_FIELD, TAG_WAVE_XT, 4);
      add_seg(RUN_FIELD, TAG_WAVE_YT, 4);
      add_seg(RUN_FIELD, TAG_WAVE_ZT, 4);
    end
  endfunction

  function automatic void clear_record();
    rec_pos   = '0;
    field_acc = '0;
    field_cnt = '0;
  endfunction

  function automatic field_word_t make_word(input logic [4:0] t, input logic [63:0] v);
    field_word_t w;
    w.tag     = t;
    w.value   = v;
    w.last    = 1'b0;
    w.rec_end = 1'b0;
    return w;
  endfunction

  // Queue up the words one stream byte produces.
  function automatic void decode_stream_byte(input logic [7:0] b);
    field_word_t run[$];
    int          i;
    int          start;
    i = 0;
    start = 0;
    if (int'(rec_pos) >= std_bytes) begin
      run.push_back(make_word(TAG_EXTRA, 64'(b)));
    end else begin
      while (int'(rec_pos) >= start + seg_size[i]) begin
        start += seg_size[i];
        i++;
      end
      if (field_cnt < 4'd8) field_acc |= 64'(b) << (8 * field_cnt);
      field_cnt = field_cnt + 4'd1;
      if (int'(rec_pos) + 1 == start + seg_size[i]) begin
        case (seg_kind[i])
          RUN_LEG_A: begin
            run.push_back(make_word(TAG_RETURN_NUM, 64'(b & LEG_RET_MASK)));
            run.push_back(make_word(TAG_NUM_RET, 64'((b & LEG_NRET_MASK) >> 3)));
            run.push_back(make_word(TAG_SCAN_DIR, 64'(b[6])));  // legacy bit six
            run.push_back(make_word(TAG_EDGE, 64'(b[7])));
          end
          RUN_LEG_B: begin
            run.push_back(make_word(TAG_CLASS, 64'(b & LEG_CLASS_MASK)));
            run.push_back(make_word(TAG_SYNTHETIC, 64'(b[5])));
            run.push_back(make_word(TAG_KEY_POINT, 64'(b[6])));
            run.push_back(make_word(TAG_WITHHELD, 64'(b[7])));
          end
          RUN_EXT_A: begin
            run.push_back(make_word(TAG_RETURN_NUM, 64'(b & EXT_RET_MASK)));
            run.push_back(make_word(TAG_NUM_RET, 64'((b & EXT_NRET_MASK) >> 4)));
          end
          RUN_EXT_B: begin
            run.push_back(make_word(TAG_SYNTHETIC, 64'(b[0])));
            run.push_back(make_word(TAG_KEY_POINT, 64'(b[1])));
            run.push_back(make_word(TAG_WITHHELD, 64'(b[2])));
            run.push_back(make_word(TAG_OVERLAP, 64'(b[3])));
            run.push_back(make_word(TAG_CHANNEL, 64'((b & EXT_CHAN_MASK) >> 4)));
            run.push_back(make_word(TAG_SCAN_DIR, 64'(b[6])));
            run.push_back(make_word(TAG_EDGE, 64'(b[7])));
          end
          default: run.push_back(make_word(seg_tag[i], field_acc));
        endcase
        field_acc = '0;
        field_cnt = '0;
      end
    end
    rec_pos = rec_pos + 9'd1;
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    if (int'(rec_pos) >= std_bytes + int'(extra_reg)) begin
      if (run.size() > 0) run[run.size() - 1].rec_end = 1'b1;
      clear_record();
    end
    foreach (run[j]) pending_fields.push_back(run[j]);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted here on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every word taken is checked against the oldest decoded word.
  always @(posedge clk) begin : field_check
    field_word_t want;
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (pending_fields.size() == 0) begin
        $error("unexpected word: field_tag %0d field_value %h", out_field_tag,
               out_field_value);
        fail_count++;
      end else begin
        want = pending_fields.pop_front();
        if (out_field_tag !== want.tag) begin
          $error("field_tag: expected %0d, got %0d", want.tag, out_field_tag);
          fail_count++;
        end
        if (out_field_value !== want.value) begin
          $error("field_value: expected %h, got %h", want.value, out_field_value);
          fail_count++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_last_of_run);
          fail_count++;
        end
        if (out_record_end !== want.rec_end) begin
          $error("record_end: expected %0b, got %0b", want.rec_end, out_record_end);
          fail_count++;
        end
        if (want.rec_end) records_closed++;
      end
    end
  end

  // cycle count and hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && !in_ready) input_stall_cycles++;
    if (cycle_count > RUN_LIMIT) begin
      $display("tb_lidar_point_record_decoder_unit: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers; all start and end at a falling edge
  // --------------------------------------------------------------------------

  // Offer one byte, with a random idle gap first, and decode it once taken.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    decode_stream_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Stop sending, let every decoded word come out, then let the block settle.
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (pending_fields.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // Register write, only from idle. Writes to a real register restart the record.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    wait_idle(DRAIN_CYCLES);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POINT_FORMAT: begin
        fmt_reg = val[3:0];
        formats_seen[val[3:0]] = 1'b1;
        clear_record();
        load_layout();
      end
      CFG_EXTRA_BYTES: begin
        extra_reg = val;
        clear_record();
      end
      default: ;
    endcase
  endtask

  // rest of the current record, random content
  task automatic send_record();
    int n;
    n = std_bytes + int'(extra_reg) - int'(rec_pos);
    repeat (n) push_byte(8'($urandom_range(255)));
  endtask

  task automatic run_phase(input logic [7:0] fmt_word, input logic [7:0] extra,
                           input int send_pct, input int stall_p);
    int sent;
    write_reg(CFG_POINT_FORMAT, fmt_word);
    write_reg(CFG_EXTRA_BYTES, extra);
    send_idle_pct = send_pct;
    stall_pct     = stall_p;
    sent = 0;
    while (sent < PHASE_BYTES) begin
      sent += std_bytes + int'(extra_reg);
      send_record();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Format 0 after reset. All-ones and all-zero fields, bit six alone in the
  // first flag byte, every bit set in the second. A write to an unused
  // register index lands mid-field and must leave the record untouched.
  task automatic test_legacy_record();
    repeat (4) push_byte(8'hFF);
    repeat (2) push_byte(8'h00);
    write_reg(CFG_IDX_W'(9), 8'hFF);
    repeat (2) push_byte(8'h00);
    push_byte(8'h01); push_byte(8'h23); push_byte(8'h45); push_byte(8'hA7);
    push_byte(8'h34); push_byte(8'hF2);
    push_byte(8'h40);                      // scan direction only
    push_byte(8'hFF);
    push_byte(8'h80); push_byte(8'h5A);
    push_byte(8'hCD); push_byte(8'hAB);
  endtask

  // A register write mid-field drops the partial record; the next bytes must
  // decode from byte zero of the new layout.
  task automatic test_record_abandon();
    repeat (3) push_byte(8'($urandom_range(255)));
    write_reg(CFG_POINT_FORMAT, 8'd7);
    repeat (6) push_byte(8'($urandom_range(255)));
  endtask

  // Four traffic phases; the last picks a format above ten, with junk in the
  // upper write data bits.
  task automatic test_random_phases();
    run_phase(8'($urandom_range(6, 10)), 8'd0, 0, 0);
    run_phase(8'($urandom_range(0, 5)), 8'($urandom_range(1, 4)), 67, 0);
    run_phase(8'd10, 8'($urandom_range(0, 3)), 0, 67);
    run_phase({4'($urandom_range(15)), 4'($urandom_range(11, 15))},
              8'($urandom_range(0, 3)), 35, 35);
  endtask

  // Receiver holds off for a long stretch while bytes keep coming, so the
  // run register fills and in_ready must drop.
  task automatic test_backpressure();
    write_reg(CFG_POINT_FORMAT, 8'd6);
    write_reg(CFG_EXTRA_BYTES, 8'd1);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 1'b1;
    send_record();
  endtask

  // Long trailer: more extra bytes than the standard part of the record.
  task automatic test_long_extra_bytes();
    write_reg(CFG_POINT_FORMAT, 8'd0);
    write_reg(CFG_EXTRA_BYTES, 8'd32);
    send_idle_pct = 35;
    stall_pct     = 35;
    send_record();
  endtask

  task automatic finish_run();
    wait_idle(DRAIN_CYCLES * 3);
    $display("Run: %0d bytes, %0d field words checked, %0d records closed, formats %b.",
             bytes_sent, words_checked, records_closed, formats_seen);
    $display("Traffic: gap-free, sender gaps, receiver stalls, both, %0d input stall cycles.",
             input_stall_cycles);
    if (fail_count == 0) begin
      $display("tb_lidar_point_record_decoder_unit: clean");
    end else begin
      $display("tb_lidar_point_record_decoder_unit: errors");
    end
    $finish;
  endtask

  initial begin
    // mirror of the reset state: format 0, no extras, start of record
    fmt_reg   = 4'd0;
    extra_reg = 8'd0;
    clear_record();
    load_layout();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_legacy_record();
    test_record_abandon();
    test_random_phases();
    test_backpressure();
    test_long_extra_bytes();
    finish_run();
  end

endmodule
